>>> hw/rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define BMTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bmts checker: property failed");

// checked on every edge, reset included
`define BMTS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bmts checker: property failed");

`endif

>>> hw/rtl/bmts_pkg.sv
package bmts_pkg;

   localparam int COORD_W          = 40;
   localparam int SCALE_W          = 32;
   localparam int EXT_W            = 40;
   localparam int IDX_W            = 8;
   localparam int SCORE_W          = 63;
   localparam int RATIO_W          = 16;
   localparam int PIXEL_SHIFT      = 8;
   localparam int ZOOM_OUT_LIMIT   = 400;
   localparam int CHUNK_W          = 14;
   localparam int CSR_INDEX_W      = 3;
   localparam int DEFAULT_MAX_MAPS = 256;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [SCALE_W-1:0] VIEW_SCALE_RESET = SCALE_W'(65536);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUERY_START_NORTH = 3'd0,
      CSR_QUERY_START_EAST  = 3'd1,
      CSR_QUERY_END_NORTH   = 3'd2,
      CSR_QUERY_END_EAST    = 3'd3,
      CSR_VIEW_SCALE        = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      JOB_SKIP,
      JOB_FULL,
      JOB_DIV
   } job_kind_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_north;
      logic signed [COORD_W-1:0] start_east;
      logic signed [COORD_W-1:0] end_north;
      logic signed [COORD_W-1:0] end_east;
      logic [SCALE_W-1:0]        view_scale;
   } query_type;

   typedef struct packed {
      job_kind_type       kind;
      logic [EXT_W-1:0]   extent_north;
      logic [EXT_W-1:0]   extent_east;
      logic [SCALE_W-1:0] numerator;
      logic [SCALE_W-1:0] denominator;
      logic [IDX_W-1:0]   index;
      logic               last;
   } job_type;

endpackage

>>> hw/rtl/bmts_front.sv
module bmts_front #(
   parameter int MAX_MAPS = bmts_pkg::DEFAULT_MAX_MAPS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bmts_pkg::query_type                   query,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_start_north,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_start_east,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_end_north,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_end_east,
   input  logic [bmts_pkg::SCALE_W-1:0]          req_map_scale_horizontal,
   input  logic [bmts_pkg::SCALE_W-1:0]          req_map_scale_vertical,
   input  logic                                  req_last_map,
   output logic                                  push_valid,
   output bmts_pkg::job_type                     push_job,
   input  logic                                  queue_full
);

   localparam int COORD_W = bmts_pkg::COORD_W;
   localparam int SCALE_W = bmts_pkg::SCALE_W;
   localparam int EXT_W   = bmts_pkg::EXT_W;
   localparam int IDX_W   = bmts_pkg::IDX_W;
   localparam int PIX_W   = EXT_W + bmts_pkg::PIXEL_SHIFT;
   localparam int ZOOM_W  = SCALE_W + 9;
   localparam int POS_W   = $clog2(MAX_MAPS + 1);

   typedef enum logic [1:0] {
      F_IDLE,
      F_CLIP,
      F_EXTENT,
      F_TEST
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic signed [COORD_W-1:0] map_start_north_ff, map_start_east_ff;
   logic signed [COORD_W-1:0] map_end_north_ff, map_end_east_ff;
   logic [SCALE_W-1:0]        scale_h_ff, scale_v_ff;
   logic                      last_ff, eligible_ff;
   logic [IDX_W-1:0]          index_ff, index_in;

   logic signed [COORD_W-1:0] clip_start_north_ff, clip_start_east_ff;
   logic signed [COORD_W-1:0] clip_end_north_ff, clip_end_east_ff;
   logic signed [COORD_W-1:0] clip_start_north_in, clip_start_east_in;
   logic signed [COORD_W-1:0] clip_end_north_in, clip_end_east_in;
   logic signed [EXT_W:0]     ext_north_ff, ext_east_ff, ext_north_in, ext_east_in;

   logic                      accept, eligible;
   logic [IDX_W+POS_W-1:0]    pos_wide;
   logic [EXT_W-1:0]          udn, ude;
   logic                      negative, pixel_fail, zoom_out, scale_equal, scale_above;
   logic [ZOOM_W-1:0]         scale_v_x400;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign eligible  = (pos_ff < POS_W'(MAX_MAPS));
   assign pos_wide  = {{IDX_W{1'b0}}, pos_ff};
   assign index_in  = pos_wide[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_CLIP;
               if (req_last_map) begin
                  pos_in = '0;
               end else if (eligible) begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         F_CLIP:   state_in = F_EXTENT;
         F_EXTENT: state_in = F_TEST;
         F_TEST: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   // clip to the query area: larger start, smaller end
   assign clip_start_north_in = (query.start_north > map_start_north_ff) ?
                                query.start_north : map_start_north_ff;
   assign clip_start_east_in  = (query.start_east > map_start_east_ff) ?
                                query.start_east : map_start_east_ff;
   assign clip_end_north_in   = (query.end_north < map_end_north_ff) ?
                                query.end_north : map_end_north_ff;
   assign clip_end_east_in    = (query.end_east < map_end_east_ff) ?
                                query.end_east : map_end_east_ff;

   assign ext_north_in = (EXT_W+1)'(clip_end_north_ff) - (EXT_W+1)'(clip_start_north_ff);
   assign ext_east_in  = (EXT_W+1)'(clip_end_east_ff) - (EXT_W+1)'(clip_start_east_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         map_start_north_ff <= req_map_start_north;
         map_start_east_ff  <= req_map_start_east;
         map_end_north_ff   <= req_map_end_north;
         map_end_east_ff    <= req_map_end_east;
         scale_h_ff         <= req_map_scale_horizontal;
         scale_v_ff         <= req_map_scale_vertical;
         last_ff            <= req_last_map;
         eligible_ff        <= eligible;
         index_ff           <= index_in;
      end
      clip_start_north_ff <= clip_start_north_in;
      clip_start_east_ff  <= clip_start_east_in;
      clip_end_north_ff   <= clip_end_north_in;
      clip_end_east_ff    <= clip_end_east_in;
      ext_north_ff        <= ext_north_in;
      ext_east_ff         <= ext_east_in;
   end

   // classification: overlap tests and which ratio path applies
   assign udn      = ext_north_ff[EXT_W-1:0];
   assign ude      = ext_east_ff[EXT_W-1:0];
   assign negative = ext_north_ff[EXT_W] | ext_east_ff[EXT_W];

   assign pixel_fail =
      ({udn, {bmts_pkg::PIXEL_SHIFT{1'b0}}} < PIX_W'(query.view_scale)) |
      ({ude, {bmts_pkg::PIXEL_SHIFT{1'b0}}} < PIX_W'(query.view_scale)) |
      ({udn, {bmts_pkg::PIXEL_SHIFT{1'b0}}} < PIX_W'(scale_v_ff)) |
      ({ude, {bmts_pkg::PIXEL_SHIFT{1'b0}}} < PIX_W'(scale_h_ff));

   assign scale_v_x400 = ZOOM_W'(scale_v_ff) * ZOOM_W'(bmts_pkg::ZOOM_OUT_LIMIT);
   assign zoom_out     = (scale_v_x400 < ZOOM_W'(query.view_scale));
   assign scale_equal  = (scale_v_ff == query.view_scale);
   assign scale_above  = (scale_v_ff > query.view_scale);

   always_comb begin
      push_job.extent_north = udn;
      push_job.extent_east  = ude;
      push_job.numerator    = scale_above ? query.view_scale : scale_v_ff;
      push_job.denominator  = scale_above ? scale_v_ff : query.view_scale;
      push_job.index        = index_ff;
      push_job.last         = last_ff;
      if (!eligible_ff || negative || pixel_fail) begin
         push_job.kind = bmts_pkg::JOB_SKIP;
      end else if (scale_equal) begin
         push_job.kind = bmts_pkg::JOB_FULL;
      end else if (!scale_above && zoom_out) begin
         push_job.kind = bmts_pkg::JOB_SKIP;
      end else begin
         push_job.kind = bmts_pkg::JOB_DIV;
      end
   end

   assign push_valid = (state_ff == F_TEST);

endmodule

>>> hw/rtl/bmts_queue.sv
module bmts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  bmts_pkg::job_type push_job,
   output logic              queue_full,
   output logic              pop_valid,
   input  logic              pop,
   output bmts_pkg::job_type pop_job
);

   localparam int DEPTH = bmts_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bmts_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_ok, pop_ok;

   assign queue_full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_ok    = push_valid & ~queue_full;
   assign pop_ok     = pop & pop_valid;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/bmts_back.sv
module bmts_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  bmts_pkg::job_type             job,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_map_found,
   output logic [bmts_pkg::IDX_W-1:0]    rsp_best_map_index,
   output logic [bmts_pkg::SCORE_W-1:0]  rsp_best_score
);

   localparam int EXT_W       = bmts_pkg::EXT_W;
   localparam int SCALE_W     = bmts_pkg::SCALE_W;
   localparam int RATIO_W     = bmts_pkg::RATIO_W;
   localparam int SCORE_W     = bmts_pkg::SCORE_W;
   localparam int IDX_W       = bmts_pkg::IDX_W;
   localparam int CHUNK_W     = bmts_pkg::CHUNK_W;
   localparam int CHUNKS      = (EXT_W + CHUNK_W - 1) / CHUNK_W;
   localparam int CHUNK_CNT_W = $clog2(CHUNKS);
   localparam int STEP_W      = $clog2(RATIO_W);
   localparam int PROD_W      = EXT_W + RATIO_W;
   localparam int PP_W        = PROD_W + CHUNK_W;
   localparam int ACC_W       = 2 * EXT_W + RATIO_W;
   localparam int DROP        = RATIO_W + 1;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIVIDE,
      B_PRODUCT,
      B_ACCUMULATE,
      B_SATURATE,
      B_UPDATE
   } back_state_type;

   back_state_type           state_ff, state_in;
   bmts_pkg::job_type        job_ff, job_in;
   logic [SCALE_W:0]         rem_ff, rem_in;
   logic [RATIO_W-1:0]       quot_ff, quot_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [CHUNK_CNT_W-1:0]   chunk_ff, chunk_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [SCORE_W-1:0]       score_ff, score_in;
   logic [SCORE_W-1:0]       best_score_ff, best_score_in;
   logic [IDX_W-1:0]         best_index_ff, best_index_in;
   logic                     best_valid_ff, best_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [SCORE_W-1:0]       rsp_score_ff, rsp_score_in;

   logic [SCALE_W:0]         rem_shift;
   logic                     take;
   logic [CHUNKS*CHUNK_W-1:0] east_pad;
   logic [CHUNK_W-1:0]       chunk_val;
   logic [PP_W-1:0]          partial;
   logic                     better;
   logic [SCORE_W-1:0]       new_score;
   logic [IDX_W-1:0]         new_index;
   logic                     new_valid;

   // restoring divider step, remainder always below the divisor
   assign rem_shift = {rem_ff[SCALE_W-1:0], 1'b0};
   assign take      = (rem_shift >= {1'b0, job_ff.denominator});

   assign east_pad  = (CHUNKS*CHUNK_W)'(job_ff.extent_east);
   assign chunk_val = east_pad[chunk_ff*CHUNK_W +: CHUNK_W];
   assign partial   = PP_W'(prod_ff) * PP_W'(chunk_val);

   assign better    = (score_ff > best_score_ff);
   assign new_score = better ? score_ff : best_score_ff;
   assign new_index = better ? job_ff.index : best_index_ff;
   assign new_valid = better | best_valid_ff;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      chunk_in      = chunk_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      score_in      = score_ff;
      best_score_in = best_score_ff;
      best_index_in = best_index_ff;
      best_valid_in = best_valid_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_score_in  = rsp_score_ff;
      job_pop       = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               rem_in   = {1'b0, job.numerator};
               quot_in  = (job.kind == bmts_pkg::JOB_FULL) ? '1 : '0;
               step_in  = '0;
               score_in = '0;
               case (job.kind)
                  bmts_pkg::JOB_DIV:  state_in = B_DIVIDE;
                  bmts_pkg::JOB_FULL: state_in = B_PRODUCT;
                  default:            state_in = B_UPDATE;
               endcase
            end
         end
         B_DIVIDE: begin
            rem_in  = take ? rem_shift - {1'b0, job_ff.denominator} : rem_shift;
            quot_in = {quot_ff[RATIO_W-2:0], take};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RATIO_W - 1)) begin
               state_in = B_PRODUCT;
            end
         end
         B_PRODUCT: begin
            prod_in  = PROD_W'(job_ff.extent_north) * PROD_W'(quot_ff);
            acc_in   = '0;
            chunk_in = '0;
            state_in = B_ACCUMULATE;
         end
         B_ACCUMULATE: begin
            // one slice of the east extent per cycle
            acc_in   = acc_ff + (ACC_W'(partial) << (chunk_ff * CHUNK_W));
            chunk_in = chunk_ff + CHUNK_CNT_W'(1);
            if (chunk_ff == CHUNK_CNT_W'(CHUNKS - 1)) begin
               state_in = B_SATURATE;
            end
         end
         B_SATURATE: begin
            score_in = (|acc_ff[ACC_W-1:DROP+SCORE_W]) ? '1 : acc_ff[DROP+SCORE_W-1:DROP];
            state_in = B_UPDATE;
         end
         B_UPDATE: begin
            if (!job_ff.last) begin
               best_score_in = new_score;
               best_index_in = new_index;
               best_valid_in = new_valid;
               state_in      = B_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = new_valid;
               rsp_index_in  = new_index;
               rsp_score_in  = new_score;
               best_score_in = '0;
               best_index_in = '0;
               best_valid_in = 1'b0;
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         best_score_ff <= '0;
         best_index_ff <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_score_ff <= best_score_in;
         best_index_ff <= best_index_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      job_ff       <= job_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      chunk_ff     <= chunk_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      score_ff     <= score_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_map_found      = rsp_found_ff;
   assign rsp_best_map_index = rsp_index_ff;
   assign rsp_best_score     = rsp_score_ff;

endmodule

>>> hw/rtl/best_map_tile_select.sv
// channel   | handshake             | carries
// req_      | req_valid/req_stall   | candidate map rectangle, scales, last_map
// rsp_      | rsp_valid/rsp_stall   | map_found, best_map_index, best_score
// csr_      | csr_valid/csr_ready   | register index and write data
//
// front end: capture, clip, extents, classify, push to a 2-entry queue, then the next map
// back end: a map on the divide path runs a 16-step restoring divider, product,
//    3 multiply-accumulate slices, saturate and update; equal scales skip the divider
//    and a skipped map only updates; the divide path rate is set by the divider
// reset is synchronous; no clearing pass, the block takes maps right after reset
// a stalled result holds; the back halts at the next last map, the front at a full queue
module best_map_tile_select #(
   parameter int MAX_MAPS = bmts_pkg::DEFAULT_MAX_MAPS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_start_north,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_start_east,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_end_north,
   input  logic signed [bmts_pkg::COORD_W-1:0]   req_map_end_east,
   input  logic [bmts_pkg::SCALE_W-1:0]          req_map_scale_horizontal,
   input  logic [bmts_pkg::SCALE_W-1:0]          req_map_scale_vertical,
   input  logic                                  req_last_map,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_map_found,
   output logic [bmts_pkg::IDX_W-1:0]            rsp_best_map_index,
   output logic [bmts_pkg::SCORE_W-1:0]          rsp_best_score,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bmts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bmts_pkg::COORD_W-1:0]          csr_data
);

   bmts_pkg::query_type query_ff, query_in;
   logic                push_valid, queue_full, pop_valid, pop;
   bmts_pkg::job_type   push_job, pop_job;

   assign csr_ready = 1'b1;

   always_comb begin
      query_in = query_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bmts_pkg::CSR_QUERY_START_NORTH: query_in.start_north = csr_data;
            bmts_pkg::CSR_QUERY_START_EAST:  query_in.start_east  = csr_data;
            bmts_pkg::CSR_QUERY_END_NORTH:   query_in.end_north   = csr_data;
            bmts_pkg::CSR_QUERY_END_EAST:    query_in.end_east    = csr_data;
            bmts_pkg::CSR_VIEW_SCALE:
               query_in.view_scale = csr_data[bmts_pkg::SCALE_W-1:0];
            default: query_in = query_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff.start_north <= '0;
         query_ff.start_east  <= '0;
         query_ff.end_north   <= '0;
         query_ff.end_east    <= '0;
         query_ff.view_scale  <= bmts_pkg::VIEW_SCALE_RESET;
      end else begin
         query_ff <= query_in;
      end
   end

   bmts_front #(
      .MAX_MAPS (MAX_MAPS)
   ) u_front (
      .clock                    (clock),
      .reset                    (reset),
      .query                    (query_ff),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_map_start_north      (req_map_start_north),
      .req_map_start_east       (req_map_start_east),
      .req_map_end_north        (req_map_end_north),
      .req_map_end_east         (req_map_end_east),
      .req_map_scale_horizontal (req_map_scale_horizontal),
      .req_map_scale_vertical   (req_map_scale_vertical),
      .req_last_map             (req_last_map),
      .push_valid               (push_valid),
      .push_job                 (push_job),
      .queue_full               (queue_full)
   );

   bmts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   bmts_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (pop_valid),
      .job                (pop_job),
      .job_pop            (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_map_found      (rsp_map_found),
      .rsp_best_map_index (rsp_best_map_index),
      .rsp_best_score     (rsp_best_score)
   );

endmodule

>>> hw/rtl/bmts_checker.sv
`include "assert_macros.svh"

module bmts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_map_found,
   input logic [bmts_pkg::IDX_W-1:0]     rsp_best_map_index,
   input logic [bmts_pkg::SCORE_W-1:0]   rsp_best_score
);

   logic [bmts_pkg::IDX_W+bmts_pkg::SCORE_W:0] rsp_payload;

   assign rsp_payload = {rsp_map_found, rsp_best_map_index, rsp_best_score};

   // no result straight out of reset
   `BMTS_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   // a stalled transaction keeps its payload
   `BMTS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // nothing found reports a zero index and score
   `BMTS_ASSERT(a_none_is_zero, clock, reset, rsp_valid && !rsp_map_found |-> rsp_payload == '0)

   // a winner always carries a positive score
   `BMTS_ASSERT(a_found_positive, clock, reset, rsp_valid && rsp_map_found |-> |rsp_best_score)

endmodule

bind best_map_tile_select bmts_checker u_bmts_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_map_found      (rsp_map_found),
   .rsp_best_map_index (rsp_best_map_index),
   .rsp_best_score     (rsp_best_score)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int COORD_W        = bmts_pkg::COORD_W;
   localparam int SCALE_W        = bmts_pkg::SCALE_W;
   localparam int SCORE_W        = bmts_pkg::SCORE_W;
   localparam int IDX_W          = bmts_pkg::IDX_W;
   localparam int RATIO_W        = bmts_pkg::RATIO_W;
   localparam int PIXEL_SHIFT    = bmts_pkg::PIXEL_SHIFT;
   localparam int ZOOM_OUT_LIMIT = bmts_pkg::ZOOM_OUT_LIMIT;
   localparam logic [SCALE_W-1:0] VIEW_SCALE_RESET = bmts_pkg::VIEW_SCALE_RESET;

   localparam int MAP_LIMIT   = bmts_pkg::DEFAULT_MAX_MAPS;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 80;
   localparam int RANDOM_MAPS = 800;
   localparam longint C_LO    = -(longint'(1) <<< (COORD_W - 1));
   localparam longint C_HI    = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
   localparam logic [SCALE_W-1:0] VIEW_MIN  = SCALE_W'(6554);
   localparam logic [SCORE_W-1:0] SCORE_TOP = '1;
   localparam logic [63:0]        RATIO_TOP = (64'd1 << RATIO_W) - 1;

   typedef struct packed {
      logic [COORD_W-1:0] start_north;
      logic [COORD_W-1:0] start_east;
      logic [COORD_W-1:0] end_north;
      logic [COORD_W-1:0] end_east;
      logic [SCALE_W-1:0] scale_horizontal;
      logic [SCALE_W-1:0] scale_vertical;
      logic               last;
   } map_item_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   index;
      logic [SCORE_W-1:0] score;
   } pick_type;

   function automatic longint sx40(logic [COORD_W-1:0] v);
      return longint'(signed'(v));
   endfunction

   // tracks the running best map of the current list and the picks still owed
   class best_map_tracker;
      bmts_pkg::query_type q;
      logic [SCORE_W-1:0]  lead_score;
      int                  lead_index;
      bit                  lead_found;
      int                  list_position;
      pick_type            expected_picks[$];
      int                  errors;

      function new();
         q = '0;
         q.view_scale = VIEW_SCALE_RESET;
         lead_score = '0;
         lead_index = 0;
         lead_found = 1'b0;
         list_position = 0;
         errors = 0;
      endfunction

      function void write_register(bmts_pkg::csr_index_type idx, logic [COORD_W-1:0] value);
         case (idx)
            bmts_pkg::CSR_QUERY_START_NORTH: q.start_north = value;
            bmts_pkg::CSR_QUERY_START_EAST:  q.start_east = value;
            bmts_pkg::CSR_QUERY_END_NORTH:   q.end_north = value;
            bmts_pkg::CSR_QUERY_END_EAST:    q.end_east = value;
            bmts_pkg::CSR_VIEW_SCALE:        q.view_scale = value[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_map(map_item_type m);
         longint             s_n, s_e, e_n, e_e;
         logic [63:0]        span_n, span_e, ratio;
         logic [127:0]       product;
         logic [SCORE_W-1:0] score;
         pick_type           pick;
         if (list_position < MAP_LIMIT) begin
            s_n = sx40(m.start_north);
            if (sx40(q.start_north) > s_n) s_n = sx40(q.start_north);
            s_e = sx40(m.start_east);
            if (sx40(q.start_east) > s_e) s_e = sx40(q.start_east);
            e_n = sx40(m.end_north);
            if (sx40(q.end_north) < e_n) e_n = sx40(q.end_north);
            e_e = sx40(m.end_east);
            if (sx40(q.end_east) < e_e) e_e = sx40(q.end_east);
            score = '0;
            if (e_n >= s_n && e_e >= s_e) begin
               span_n = e_n - s_n;
               span_e = e_e - s_e;
               // overlap must cover a view pixel and a map pixel on both axes
               if ((span_n << PIXEL_SHIFT) >= q.view_scale &&
                   (span_e << PIXEL_SHIFT) >= q.view_scale &&
                   (span_n << PIXEL_SHIFT) >= m.scale_vertical &&
                   (span_e << PIXEL_SHIFT) >= m.scale_horizontal) begin
                  if (m.scale_vertical == q.view_scale) begin
                     ratio = RATIO_TOP;
                  end else if (m.scale_vertical > q.view_scale) begin
                     ratio = (64'(q.view_scale) << RATIO_W) / m.scale_vertical;
                  end else if (64'(m.scale_vertical) * ZOOM_OUT_LIMIT < 64'(q.view_scale)) begin
                     ratio = '0;
                  end else begin
                     ratio = (64'(m.scale_vertical) << RATIO_W) / q.view_scale;
                  end
                  if (ratio > RATIO_TOP) ratio = RATIO_TOP;
                  product = (128'(span_n) * 128'(span_e) * 128'(ratio)) >> (RATIO_W + 1);
                  score = (product > 128'(SCORE_TOP)) ? SCORE_TOP : product[SCORE_W-1:0];
               end
            end
            if (score > lead_score) begin
               lead_score = score;
               lead_index = list_position;
               lead_found = 1'b1;
            end
            list_position++;
         end
         if (m.last) begin
            pick.found = lead_found;
            pick.index = lead_found ? IDX_W'(lead_index) : '0;
            pick.score = lead_found ? lead_score : '0;
            expected_picks.push_back(pick);
            lead_score = '0;
            lead_index = 0;
            lead_found = 1'b0;
            list_position = 0;
         end
      endfunction

      function void check_pick(pick_type got);
         pick_type want;
         if (expected_picks.size() == 0) begin
            $display("%0t: result with none pending, found %0d index %0d score %0d",
                     $time, got.found, got.index, got.score);
            errors++;
            return;
         end
         want = expected_picks.pop_front();
         if (got.found !== want.found) begin
            $display("%0t: map_found expected %0d, got %0d", $time, want.found, got.found);
            errors++;
         end
         if (got.index !== want.index) begin
            $display("%0t: best_map_index expected %0d, got %0d", $time, want.index, got.index);
            errors++;
         end
         if (got.score !== want.score) begin
            $display("%0t: best_score expected %0d, got %0d", $time, want.score, got.score);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_map_start_north = '0;
   logic signed [COORD_W-1:0] req_map_start_east = '0;
   logic signed [COORD_W-1:0] req_map_end_north = '0;
   logic signed [COORD_W-1:0] req_map_end_east = '0;
   logic [SCALE_W-1:0]        req_map_scale_horizontal = '0;
   logic [SCALE_W-1:0]        req_map_scale_vertical = '0;
   logic                      req_last_map = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_map_found;
   logic [IDX_W-1:0]          rsp_best_map_index;
   logic [SCORE_W-1:0]        rsp_best_score;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   bmts_pkg::csr_index_type   csr_index = bmts_pkg::CSR_QUERY_START_NORTH;
   logic [COORD_W-1:0]        csr_data = '0;

   best_map_tracker     tracker = new();
   bmts_pkg::query_type cur_query;
   bit                  idle_off = 1'b0;
   int                  random_sent = 0;

   best_map_tile_select #(.MAX_MAPS(MAP_LIMIT)) i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_register(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            tracker.note_map({req_map_start_north, req_map_start_east, req_map_end_north,
                              req_map_end_east, req_map_scale_horizontal,
                              req_map_scale_vertical, req_last_map});
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_pick({rsp_map_found, rsp_best_map_index, rsp_best_score});
         end
      end
   end

   function automatic int draw_gap();
      return idle_off ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic longint unsigned rand_below(longint unsigned span);
      return {$urandom, $urandom} % span;
   endfunction

   function automatic map_item_type make_map(longint sn, longint se, longint en, longint ee,
                                             logic [SCALE_W-1:0] sh, logic [SCALE_W-1:0] sv,
                                             bit last);
      map_item_type m;
      m.start_north = COORD_W'(sn);
      m.start_east = COORD_W'(se);
      m.end_north = COORD_W'(en);
      m.end_east = COORD_W'(ee);
      m.scale_horizontal = sh;
      m.scale_vertical = sv;
      m.last = last;
      return m;
   endfunction

   function automatic bmts_pkg::query_type make_query(longint sn, longint se, longint en,
                                                      longint ee, logic [SCALE_W-1:0] view);
      bmts_pkg::query_type qq;
      qq.start_north = COORD_W'(sn);
      qq.start_east = COORD_W'(se);
      qq.end_north = COORD_W'(en);
      qq.end_east = COORD_W'(ee);
      qq.view_scale = view;
      return qq;
   endfunction

   function automatic bmts_pkg::query_type random_query();
      longint             c_n, c_e, s_n, s_e;
      logic [SCALE_W-1:0] view;
      case ($urandom_range(0, 7))
         0: view = VIEW_MIN;
         1: view = SCALE_MAX;
         2: view = VIEW_SCALE_RESET;
         default: view = $urandom_range(6554, 1 << 22);
      endcase
      c_n = longint'(rand_below(64'd1 << 31)) - (longint'(1) << 30);
      c_e = longint'(rand_below(64'd1 << 31)) - (longint'(1) << 30);
      s_n = longint'(rand_below(64'd1 << $urandom_range(12, 34))) + 256;
      s_e = longint'(rand_below(64'd1 << $urandom_range(12, 34))) + 256;
      case ($urandom_range(0, 7))
         0: return make_query(C_LO, C_LO, C_HI, C_HI, view);
         1: return make_query(c_n, c_e, c_n - s_n, c_e - s_e, view);   // inverted query
         default: return make_query(c_n, c_e, c_n + s_n, c_e + s_e, view);
      endcase
   endfunction

   // candidate edges scattered around one query axis, wrapping at the coordinate width
   function automatic void place_span(input longint q_lo, input longint q_hi,
                                      output logic [COORD_W-1:0] lo,
                                      output logic [COORD_W-1:0] hi);
      longint len, a, b;
      len = q_hi - q_lo;
      if (len <= 0) len = 65536;
      if ($urandom_range(0, 5) == 0) begin
         lo = COORD_W'(q_lo);
         hi = COORD_W'(q_hi);
      end else begin
         a = q_lo + longint'(rand_below(64'(2 * len + 1))) - len;
         b = a + longint'(rand_below(64'(2 * len + 1))) - len / 8;
         lo = COORD_W'(a);
         hi = COORD_W'(b);
      end
   endfunction

   function automatic map_item_type random_map(bit last);
      map_item_type       m;
      logic [SCALE_W-1:0] v;
      v = cur_query.view_scale;
      if ($urandom_range(0, 9) == 0) begin
         m.start_north = COORD_W'({$urandom, $urandom});
         m.start_east = COORD_W'({$urandom, $urandom});
         m.end_north = COORD_W'({$urandom, $urandom});
         m.end_east = COORD_W'({$urandom, $urandom});
         m.scale_horizontal = $urandom;
         m.scale_vertical = $urandom;
      end else begin
         place_span(sx40(cur_query.start_north), sx40(cur_query.end_north),
                    m.start_north, m.end_north);
         place_span(sx40(cur_query.start_east), sx40(cur_query.end_east),
                    m.start_east, m.end_east);
         case ($urandom_range(0, 6))
            0: m.scale_vertical = v;
            1: m.scale_vertical = v + SCALE_W'($urandom_range(1, 3));
            2: m.scale_vertical = v / SCALE_W'($urandom_range(1, 600));
            3: m.scale_vertical = v - SCALE_W'($urandom_range(0, v >> 1));
            4: m.scale_vertical = $urandom;
            5: m.scale_vertical = $urandom_range(0, 3);
            default: m.scale_vertical = v << $urandom_range(1, 3);
         endcase
         m.scale_horizontal = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
      end
      m.last = last;
      return m;
   endfunction

   // entered and left at a falling edge
   task automatic send_map(map_item_type m);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_map_start_north <= m.start_north;
      req_map_start_east <= m.start_east;
      req_map_end_north <= m.end_north;
      req_map_end_east <= m.end_east;
      req_map_scale_horizontal <= m.scale_horizontal;
      req_map_scale_vertical <= m.scale_vertical;
      req_last_map <= m.last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_list(int length);
      map_item_type m;
      for (int i = 0; i < length; i++) begin
         // now and then repeat the previous map so that ties come up
         if (i > 0 && $urandom_range(0, 7) == 0) m.last = (i == length - 1);
         else m = random_map(i == length - 1);
         send_map(m);
         random_sent++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.expected_picks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(bmts_pkg::csr_index_type idx, logic [COORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_query(bmts_pkg::query_type qq);
      drain();
      @(negedge clock);
      write_csr(bmts_pkg::CSR_QUERY_START_NORTH, qq.start_north);
      write_csr(bmts_pkg::CSR_QUERY_START_EAST, qq.start_east);
      write_csr(bmts_pkg::CSR_QUERY_END_NORTH, qq.end_north);
      write_csr(bmts_pkg::CSR_QUERY_END_EAST, qq.end_east);
      write_csr(bmts_pkg::CSR_VIEW_SCALE, COORD_W'(qq.view_scale));
      csr_valid <= 1'b0;
      cur_query = qq;
   endtask

   initial begin : result_side
      int hold;
      do @(negedge clock); while (reset);
      forever begin
         hold = draw_gap();
         rsp_stall <= (hold != 0);
         do @(posedge clock); while (!rsp_valid);
         if (hold != 0) begin
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench: errors");
      $finish;
   end

   initial begin : stimulus
      int lists;
      int list_len;
      cur_query = make_query(0, 0, 0, 0, VIEW_SCALE_RESET);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset query is empty, nothing can score
      send_map(make_map(-256, -256, 256, 256, 65536, 65536, 1'b1));

      load_query(make_query(0, 0, 65536, 65536, 65536));
      send_map(make_map(0, 0, 65536, 65536, 65536, 65536, 1'b0));
      send_map(make_map(0, 0, 65536, 65536, 65536, 65536, 1'b0));   // tie, first keeps it
      send_map(make_map(40000, 40000, 30000, 30000, 65536, 65536, 1'b0));
      send_map(make_map(0, 0, 65536, 65536, 0, 0, 1'b0));
      send_map(make_map(C_LO, C_LO, C_HI, C_HI, 65536, 131072, 1'b0));
      send_map(make_map(0, 0, 65536, 65536, 65536, 164, 1'b0));    // just above zoom-out floor
      send_map(make_map(0, 0, 65536, 65536, 65536, 163, 1'b0));    // just below it
      send_map(make_map(0, 0, 65536, 65536, SCALE_MAX, 65536, 1'b0));
      send_map(make_map(0, 0, 32768, 32768, 65536, 65536, 1'b1));
      send_map(make_map(0, 0, 32768, 32768, 65536, 65536, 1'b0));
      send_map(make_map(0, 0, 65536, 65536, 65536, 65536, 1'b1));   // later map wins

      load_query(make_query(C_LO, C_LO, C_HI, C_HI, SCALE_MAX));
      send_map(make_map(C_LO, C_LO, C_LO, C_LO, 0, 0, 1'b0));
      send_map(make_map(C_HI, C_HI, C_HI, C_HI, SCALE_MAX, SCALE_MAX, 1'b0));
      send_map(make_map(C_LO, C_LO, C_HI, C_HI, SCALE_MAX, SCALE_MAX, 1'b1));   // saturates

      load_query(make_query(-512, -512, 512, 512, VIEW_MIN));
      send_map(make_map(C_LO, C_LO, C_HI, C_HI, 1, 1, 1'b0));
      send_map(make_map(-512, -512, 512, 512, 17, 17, 1'b1));

      // zero view scale
      load_query(make_query(0, 0, 256, 256, 0));
      send_map(make_map(0, 0, 256, 256, 0, 0, 1'b0));
      send_map(make_map(0, 0, 256, 256, 5, 5, 1'b1));

      random_sent = 0;
      for (int phase = 0; random_sent < RANDOM_MAPS; phase++) begin
         // the long list runs against a plain query so that scores stay positive
         if (phase == 2) load_query(make_query(0, 0, 64'sd1 << 20, 64'sd1 << 20, 65536));
         else load_query(random_query());
         lists = $urandom_range(3, 8);
         for (int n = 0; n < lists; n++) begin
            idle_off = ($urandom_range(0, 4) == 0);
            if (phase == 2 && n == 0) list_len = MAP_LIMIT + 14;
            else if ($urandom_range(0, 5) == 0) list_len = $urandom_range(9, 40);
            else list_len = $urandom_range(1, 8);
            send_list(list_len);
         end
      end

      drain();
      if (tracker.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bmts_pkg.sv
hw/rtl/bmts_front.sv
hw/rtl/bmts_queue.sv
hw/rtl/bmts_back.sv
hw/rtl/best_map_tile_select.sv
hw/rtl/bmts_checker.sv
bench/testbench.sv
